// ===== rtl/sha_pkg.sv =====
// SHA-256 hasher package: shared types, constants, round functions.
// No dependencies; used by every module of the hasher.
`default_nettype none
package sha_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_RUN,
		ST_EMIT
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic put_byte;       // write byte_val into block buffer
		logic [7:0] byte_val;
		logic count_inc;      // bump byte count
		logic start_block;    // load working vars, clear round counter
		logic round;          // run one round
		logic finish_block;   // fold working vars into hash
		logic emit_adv;       // advance digest word pointer
		logic clear_msg;      // reset hash, count, fill
		logic snap_len;       // latch bit length for padding
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic [5:0] fill;
		logic [5:0] round_idx;
		logic [7:0] len_byte; // length byte for current fill position
	} stat_t;

	localparam logic [7:0] PAD_MARK = 8'h80;
	localparam logic [5:0] LEN_POS  = 6'd56;

	localparam logic [31:0] INIT_HASH [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

endpackage
`default_nettype wire

// ===== rtl/sha_ctrl.sv =====
// SHA-256 hasher controller: sequences byte intake, padding, rounds, digest.
// Depends on sha_pkg.
`default_nettype none
module sha_ctrl (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_ready,
	input  wire logic [7:0] in_byte,
	input  wire logic in_has,
	input  wire logic in_last,
	output logic out_valid,
	input  wire logic out_ready,
	output logic [2:0] out_idx,
	output sha_pkg::cmd_t cmd,
	input  wire sha_pkg::stat_t stat
);
	sha_pkg::state_t state_q, state_d;
	sha_pkg::state_t ret_q, ret_d;  // where to go after a block
	logic [2:0] widx_q;
	logic len_phase_q;              // padding reached the length bytes
	logic mark_done_q;
	logic need_extra_q;
	logic len_ok;

	logic acc;
	logic pad_put;
	logic fill_wraps;

	assign acc = in_valid && in_ready;
	assign fill_wraps = (stat.fill == 6'd63);
	assign pad_put = (state_q == sha_pkg::ST_PAD);
	// length bytes go in once the padding sits in the final block
	assign len_ok = mark_done_q && (stat.fill >= sha_pkg::LEN_POS) && !need_extra_q;

	always_comb begin
		state_d = state_q;
		ret_d = ret_q;
		case (state_q)
			sha_pkg::ST_IDLE: begin
				if (acc) begin
					if (in_has && fill_wraps) begin
						state_d = sha_pkg::ST_RUN;
						ret_d = in_last ? sha_pkg::ST_PAD : sha_pkg::ST_IDLE;
					end else if (in_last) begin
						state_d = sha_pkg::ST_PAD;
					end
				end
			end
			sha_pkg::ST_PAD: begin
				if (fill_wraps) begin
					state_d = sha_pkg::ST_RUN;
					ret_d = len_phase_q ? sha_pkg::ST_EMIT : sha_pkg::ST_PAD;
				end
			end
			sha_pkg::ST_RUN: begin
				if (stat.round_idx == 6'd63) state_d = ret_q;
			end
			sha_pkg::ST_EMIT: begin
				if (out_ready && widx_q == 3'd7) state_d = sha_pkg::ST_IDLE;
			end
			default: state_d = sha_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = (state_q == sha_pkg::ST_IDLE);
		out_valid = (state_q == sha_pkg::ST_EMIT);
		out_idx = widx_q;
		case (state_q)
			sha_pkg::ST_IDLE: begin
				cmd.put_byte = acc && in_has;
				cmd.byte_val = in_byte;
				cmd.count_inc = acc && in_has;
				cmd.start_block = acc && in_has && fill_wraps;
			end
			sha_pkg::ST_PAD: begin
				cmd.put_byte = 1'b1;
				cmd.start_block = fill_wraps;
			end
			sha_pkg::ST_RUN: begin
				cmd.round = 1'b1;
				cmd.finish_block = (stat.round_idx == 6'd63);
			end
			sha_pkg::ST_EMIT: begin
				cmd.emit_adv = out_ready;
				cmd.clear_msg = out_ready && widx_q == 3'd7;
			end
			default: ;
		endcase
		// padding byte choice
		if (pad_put) begin
			if (!mark_done_q) cmd.byte_val = sha_pkg::PAD_MARK;
			else if (stat.fill >= sha_pkg::LEN_POS && len_ok) cmd.byte_val = stat.len_byte;
			else cmd.byte_val = 8'h00;
		end
		cmd.snap_len = acc && in_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sha_pkg::ST_IDLE;
			ret_q <= sha_pkg::ST_IDLE;
			widx_q <= '0;
			len_phase_q <= 1'b0;
			mark_done_q <= 1'b0;
			need_extra_q <= 1'b0;
		end else begin
			state_q <= state_d;
			ret_q <= ret_d;
			if (cmd.emit_adv) widx_q <= widx_q + 3'd1;
			if (state_q == sha_pkg::ST_IDLE) begin
				mark_done_q <= 1'b0;
				len_phase_q <= 1'b0;
			end
			if (pad_put) begin
				if (!mark_done_q) begin
					mark_done_q <= 1'b1;
					// mark at fill >= 56 leaves no room for length here;
					// a mark in the last byte already closes this block
					need_extra_q <= (stat.fill >= sha_pkg::LEN_POS) && !fill_wraps;
					len_phase_q <= (stat.fill < sha_pkg::LEN_POS) || fill_wraps;
				end else if (fill_wraps) begin
					need_extra_q <= 1'b0;
					len_phase_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (arst_n && state_q == sha_pkg::ST_RUN && stat.round_idx == 6'd63)
			assert (ret_q != sha_pkg::ST_RUN) else $error("run returns to run");
	end

	a_emit_only: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("emit while taking input");
	a_run_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sha_pkg::ST_RUN) |-> !in_ready) else $error("input in run");
	a_widx: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sha_pkg::ST_IDLE) |-> widx_q == 3'd0) else $error("word ptr not cleared");
endmodule
`default_nettype wire

// ===== rtl/sha_dp.sv =====
// SHA-256 hasher datapath: block buffer, schedule window, round unit, hash.
// Depends on sha_pkg.
`default_nettype none
module sha_dp (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire sha_pkg::cmd_t cmd,
	output sha_pkg::stat_t stat,
	input  wire logic [2:0] out_idx,
	output logic [31:0] digest
);
	logic [31:0] hash_q [8];
	logic [31:0] blk_q [16];   // message words, then 16-word schedule window
	logic [31:0] wv_q [8];
	logic [60:0] count_q;
	logic [5:0] fill_q;
	logic [5:0] rnd_q;
	logic [63:0] bits_q;

	logic [3:0] wsel;
	logic [1:0] bsel;
	assign wsel = fill_q[5:2];
	assign bsel = fill_q[1:0];

	logic [31:0] w_cur, s0, s1, w_new, big0, big1, ch, maj, t1, t2;
	assign w_cur = blk_q[0];
	assign s0 = sha_pkg::rotr(blk_q[1], 7) ^ sha_pkg::rotr(blk_q[1], 18) ^ (blk_q[1] >> 3);
	assign s1 = sha_pkg::rotr(blk_q[14], 17) ^ sha_pkg::rotr(blk_q[14], 19)
		^ (blk_q[14] >> 10);
	assign w_new = s1 + blk_q[9] + s0 + blk_q[0];
	assign big1 = sha_pkg::rotr(wv_q[4], 6) ^ sha_pkg::rotr(wv_q[4], 11)
		^ sha_pkg::rotr(wv_q[4], 25);
	assign ch = (wv_q[4] & wv_q[5]) ^ (~wv_q[4] & wv_q[6]);
	assign t1 = wv_q[7] + big1 + ch + sha_pkg::ROUND_K[rnd_q] + w_cur;
	assign big0 = sha_pkg::rotr(wv_q[0], 2) ^ sha_pkg::rotr(wv_q[0], 13)
		^ sha_pkg::rotr(wv_q[0], 22);
	assign maj = (wv_q[0] & wv_q[1]) ^ (wv_q[0] & wv_q[2]) ^ (wv_q[1] & wv_q[2]);
	assign t2 = big0 + maj;

	logic [2:0] lsel;
	assign lsel = fill_q[2:0];
	assign stat.fill = fill_q;
	assign stat.round_idx = rnd_q;
	assign stat.len_byte = bits_q[6'd63 - {lsel, 3'b000} -: 8];
	assign digest = hash_q[out_idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) hash_q[i] <= sha_pkg::INIT_HASH[i];
			count_q <= '0;
			fill_q <= '0;
			rnd_q <= '0;
		end else begin
			if (cmd.put_byte) fill_q <= fill_q + 6'd1;
			if (cmd.count_inc) count_q <= count_q + 61'd1;
			if (cmd.start_block) rnd_q <= '0;
			else if (cmd.round) rnd_q <= rnd_q + 6'd1;
			if (cmd.finish_block) begin
				hash_q[0] <= hash_q[0] + t1 + t2;
				for (int i = 1; i < 8; i++) begin
					if (i == 4) hash_q[i] <= hash_q[i] + wv_q[3] + t1;
					else hash_q[i] <= hash_q[i] + wv_q[i - 1];
				end
			end
			if (cmd.clear_msg) begin
				for (int i = 0; i < 8; i++) hash_q[i] <= sha_pkg::INIT_HASH[i];
				count_q <= '0;
				fill_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.snap_len) bits_q <= {count_q + 61'(cmd.count_inc), 3'b000};
		if (cmd.put_byte)
			blk_q[wsel][5'd24 - {bsel, 3'b000} +: 8] <= cmd.byte_val;
		if (cmd.start_block)
			for (int i = 0; i < 8; i++) wv_q[i] <= hash_q[i];
		if (cmd.round) begin
			for (int i = 0; i < 15; i++) blk_q[i] <= blk_q[i + 1];
			blk_q[15] <= w_new;
			wv_q[7] <= wv_q[6];
			wv_q[6] <= wv_q[5];
			wv_q[5] <= wv_q[4];
			wv_q[4] <= wv_q[3] + t1;
			wv_q[3] <= wv_q[2];
			wv_q[2] <= wv_q[1];
			wv_q[1] <= wv_q[0];
			wv_q[0] <= t1 + t2;
		end
	end

	a_fill_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.round |=> $stable(fill_q)) else $error("fill moved during rounds");
	a_no_mix: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.round && cmd.put_byte)) else $error("byte write during rounds");
	a_rnd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start_block |=> rnd_q == 6'd0) else $error("round counter not cleared");
endmodule
`default_nettype wire

// ===== rtl/sha256_byte_stream_hasher.sv =====
// SHA-256 byte-stream hasher top level: wires controller to datapath.
// Depends on sha_pkg, sha_ctrl, sha_dp.
//
// channel   dir  tdata                      tuser / tlast
// s_axis    in   [7:0] data_byte            tuser has_byte, tlast is_last
// m_axis    out  [31:0] digest_word         tuser [2:0] word_index, tlast last_word
//
// Each byte beat is taken while idle; the 64th byte of a block starts the
// shared round unit (one round per cycle), which runs the block's 64 rounds
// before more input is taken. A last beat adds padding bytes, one or two
// blocks of 64 rounds, then 8 digest beats at the pace of m_axis_tready.
// arst_n loads the initial hash and clears count, fill and controller.
// No input beat is taken from a last beat until the eighth digest beat.
`default_nettype none
module sha256_byte_stream_hasher (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_axis_tvalid,
	output logic s_axis_tready,
	input  wire logic [7:0] s_axis_tdata,   // [7:0] data_byte
	input  wire logic s_axis_tuser,         // [0] has_byte
	input  wire logic s_axis_tlast,
	output logic m_axis_tvalid,
	input  wire logic m_axis_tready,
	output logic [31:0] m_axis_tdata,       // [31:0] digest_word
	output logic [2:0] m_axis_tuser,        // [2:0] word_index
	output logic m_axis_tlast
);
	sha_pkg::cmd_t cmd;
	sha_pkg::stat_t stat;
	logic [2:0] idx;

	sha_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_byte(s_axis_tdata), .in_has(s_axis_tuser), .in_last(s_axis_tlast),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_idx(idx),
		.cmd(cmd), .stat(stat)
	);

	sha_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.out_idx(idx), .digest(m_axis_tdata)
	);

	assign m_axis_tuser = idx;
	assign m_axis_tlast = (idx == 3'd7);
endmodule
`default_nettype wire
